// ===== rtl/core/fcba_pkg.sv =====
`timescale 1ns / 1ps

package fcba_pkg;

    // field widths
    localparam int MODE_W    = 2;
    localparam int SIZE_W    = 18;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int BB_W      = 13;
    localparam int STATUS_W  = 2;
    localparam int MARK_W    = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic [BB_W-1:0] BB_RESET = 13'd512;

    // serial divider
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(SIZE_W - 1);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD      = 2'd3;

    // table entry marks
    localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LINK = 2'd1;
    localparam logic [MARK_W-1:0] MARK_END  = 2'd2;
    localparam logic [MARK_W-1:0] MARK_RSVD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DIV_WAIT,
        ST_ALLOC_SCAN,
        ST_ALLOC_TAIL,
        ST_FREE_WALK,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              clear;
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [MARK_W-1:0] wmark;
        logic [IDX_W-1:0]  wlink;
        logic [IDX_W-1:0]  raddr;
    } tbl_req_t;

    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [IDX_W-1:0]  link;
    } tbl_rsp_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] quo;
        logic              rem_nz;
    } div_rsp_t;

endpackage

// ===== rtl/core/fat_chain_block_allocator.sv =====
`timescale 1ns / 1ps

// File allocation table allocator over FAT_ENTRIES linked block entries.
// Input stream: s_tuser carries the operation (clear, allocate, free chain,
// read entry); s_tdata carries the byte size and the start/entry index.
// Result stream: one transfer per input transfer, status in m_tuser, chain
// head, block count, link and entry marks in m_tdata.
// One operation is in flight at a time; s_tready is high only while idle.
// Allocate waits on the serial divider for the block count, then scans the
// table memory at one entry a cycle; free chain follows one link a cycle
// through the table memory's read port.
// The finished result sits in an output register; the next operation is
// taken while it waits, and only its own result waits for m_tready.
// block_bytes must be written on the APB-style port only while the block is
// idle; the block does not enforce it. A value of zero acts as one.
// Reset: synchronous, active low; all entries read as free at once (per-entry
// valid bits, no clearing pass), block_bytes returns to 512.
module fat_chain_block_allocator #(
    parameter int FAT_ENTRIES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // size_bytes[17:0], start_index[23:18]
    input  logic [fcba_pkg::S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [fcba_pkg::MODE_W-1:0]    s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // first_index[5:0], block_count[12:6], next_index[18:13], is_end[19],
    // is_free[20], zero fill [23:21]
    output logic [fcba_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [fcba_pkg::STATUS_W-1:0]  m_tuser,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fcba_pkg::APB_AW-1:0]    paddr,
    input  logic [fcba_pkg::APB_DW-1:0]    pwdata,
    output logic [fcba_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import fcba_pkg::*;

    localparam logic [CNT_W-1:0] NUM_ENTRIES = CNT_W'(FAT_ENTRIES);

    state_t              state_reg, state_next;
    logic [BB_W-1:0]     bb_reg, bb_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [STATUS_W-1:0] out_user_reg, out_user_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [CNT_W-1:0]    need_reg, need_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [CNT_W-1:0]    got_reg, got_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_first_reg, res_first_next;
    logic [CNT_W-1:0]    res_count_reg, res_count_next;
    logic [IDX_W-1:0]    res_link_reg, res_link_next;
    logic                res_end_reg, res_end_next;
    logic                res_free_reg, res_free_next;

    tbl_req_t            tbl_req;
    tbl_rsp_t            tbl_rsp;
    div_rsp_t            div_rsp;
    logic                div_start;
    logic [BB_W-1:0]     divisor;
    logic [SIZE_W:0]     need_full;
    logic                out_free;
    logic                start_out;
    logic                cfg_write;
    logic [CNT_W-1:0]    cnt_inc;

    fcba_table #(
        .FAT_ENTRIES(FAT_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rsp     (tbl_rsp)
    );

    fcba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (size_reg),
        .divisor  (divisor),
        .rsp      (div_rsp)
    );

    assign divisor   = (bb_reg == '0) ? BB_W'(1) : bb_reg;
    assign need_full = {1'b0, div_rsp.quo} + (SIZE_W+1)'(div_rsp.rem_nz);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign start_out = ({1'b0, start_reg} >= NUM_ENTRIES);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[APB_AW-1] == REG_BLOCK_BYTES) ? APB_DW'(bb_reg) : '0;

    always_comb begin
        state_next      = state_reg;
        bb_next         = bb_reg;
        free_cnt_next   = free_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        mode_next       = mode_reg;
        size_next       = size_reg;
        start_next      = start_reg;
        need_next       = need_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        pidx_next       = pidx_reg;
        prev_next       = prev_reg;
        got_next        = got_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        res_count_next  = res_count_reg;
        res_link_next   = res_link_reg;
        res_end_next    = res_end_reg;
        res_free_next   = res_free_reg;
        tbl_req         = '0;
        tbl_req.raddr   = start_reg;
        div_start       = 1'b0;

        if (cfg_write && (paddr[APB_AW-1] == REG_BLOCK_BYTES)) begin
            bb_next = pwdata[BB_W-1:0];
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = s_tuser;
                    size_next  = s_tdata[SIZE_W-1:0];
                    start_next = s_tdata[SIZE_W+IDX_W-1:SIZE_W];
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                res_status_next = STAT_OK;
                res_first_next  = '0;
                res_count_next  = '0;
                res_link_next   = '0;
                res_end_next    = 1'b0;
                res_free_next   = 1'b0;
                case (mode_reg)
                    MODE_CLEAR: begin
                        tbl_req.clear = 1'b1;
                        free_cnt_next = NUM_ENTRIES;
                        state_next    = ST_DONE;
                    end
                    MODE_ALLOC: begin
                        if (size_reg == '0) begin
                            res_status_next = STAT_EMPTY;
                            state_next      = ST_DONE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV_WAIT;
                        end
                    end
                    MODE_FREE: begin
                        cur_next = start_reg;
                        cnt_next = '0;
                        if (start_out) begin
                            res_status_next = STAT_BAD;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_FREE_WALK;
                        end
                    end
                    default: begin
                        if (start_out) begin
                            res_status_next = STAT_BAD;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_READ_WAIT;
                        end
                    end
                endcase
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (need_full > (SIZE_W+1)'(free_cnt_reg)) begin
                        res_status_next = STAT_NO_SPACE;
                        state_next      = ST_DONE;
                    end else begin
                        need_next  = need_full[CNT_W-1:0];
                        scan_next  = '0;
                        pend_next  = 1'b0;
                        got_next   = '0;
                        state_next = ST_ALLOC_SCAN;
                    end
                end
            end
            ST_ALLOC_SCAN: begin
                // reads run one entry ahead of the link writes, which only touch lower entries
                tbl_req.raddr = scan_reg[IDX_W-1:0];
                if (scan_reg < NUM_ENTRIES) begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && (tbl_rsp.mark == MARK_FREE)) begin
                    if (got_reg == '0) begin
                        res_first_next = pidx_reg;
                    end else begin
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = prev_reg;
                        tbl_req.wmark = MARK_LINK;
                        tbl_req.wlink = pidx_reg;
                    end
                    prev_next = pidx_reg;
                    got_next  = got_reg + 1'b1;
                    if ((got_reg + 1'b1) == need_reg) begin
                        state_next = ST_ALLOC_TAIL;
                    end
                end
            end
            ST_ALLOC_TAIL: begin
                tbl_req.we      = 1'b1;
                tbl_req.waddr   = prev_reg;
                tbl_req.wmark   = MARK_END;
                tbl_req.wlink   = prev_reg;
                res_count_next  = need_reg;
                free_cnt_next   = free_cnt_reg - need_reg;
                state_next      = ST_DONE;
            end
            ST_FREE_WALK: begin
                // follow the link straight from the read data
                tbl_req.raddr = tbl_rsp.link;
                if (tbl_rsp.mark == MARK_FREE) begin
                    res_status_next = (cnt_reg == '0) ? STAT_BAD : STAT_OK;
                    res_count_next  = cnt_reg;
                    free_cnt_next   = free_cnt_reg + cnt_reg;
                    state_next      = ST_DONE;
                end else begin
                    tbl_req.we    = 1'b1;
                    tbl_req.waddr = cur_reg;
                    tbl_req.wmark = MARK_FREE;
                    tbl_req.wlink = tbl_rsp.link;
                    cnt_next      = cnt_inc;
                    cur_next      = tbl_rsp.link;
                    if ((tbl_rsp.mark != MARK_LINK) ||
                        ({1'b0, tbl_rsp.link} >= NUM_ENTRIES) ||
                        (cnt_inc == NUM_ENTRIES)) begin
                        res_count_next = cnt_inc;
                        free_cnt_next  = free_cnt_reg + cnt_inc;
                        state_next     = ST_DONE;
                    end
                end
            end
            ST_READ_WAIT: begin
                res_link_next = (tbl_rsp.mark == MARK_LINK) ? tbl_rsp.link : '0;
                res_end_next  = (tbl_rsp.mark == MARK_END) || (tbl_rsp.mark == MARK_RSVD);
                res_free_next = (tbl_rsp.mark == MARK_FREE);
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_user_next = res_status_reg;
                    out_data_next = {3'b000, res_free_reg, res_end_reg, res_link_reg,
                                     res_count_reg, res_first_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bb_reg       <= BB_RESET;
            free_cnt_reg <= NUM_ENTRIES;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bb_reg       <= bb_next;
            free_cnt_reg <= free_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
        mode_reg       <= mode_next;
        size_reg       <= size_next;
        start_reg      <= start_next;
        need_reg       <= need_next;
        scan_reg       <= scan_next;
        pend_reg       <= pend_next;
        pidx_reg       <= pidx_next;
        prev_reg       <= prev_next;
        got_reg        <= got_next;
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_count_reg  <= res_count_next;
        res_link_reg   <= res_link_next;
        res_end_reg    <= res_end_next;
        res_free_reg   <= res_free_next;
    end

    a_free_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_cnt_reg <= NUM_ENTRIES)
        else $error("free entry count above table size");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while an operation is in flight");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion step");

    a_scan_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALLOC_SCAN) |-> (got_reg < need_reg))
        else $error("allocation scan claimed more entries than requested");

endmodule

// ===== rtl/core/fcba_div.sv =====
`timescale 1ns / 1ps

module fcba_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fcba_pkg::SIZE_W-1:0] dividend,
    input  logic [fcba_pkg::BB_W-1:0]   divisor,
    output fcba_pkg::div_rsp_t          rsp
);
    import fcba_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [BB_W-1:0]      rem_reg, rem_next;
    logic [SIZE_W-1:0]    quo_reg, quo_next;
    logic [BB_W-1:0]      dvs_reg, dvs_next;
    logic [BB_W:0]        shifted;
    logic [BB_W:0]        diff;
    logic                 ge;

    // restoring division, one quotient bit a cycle, msb first
    always_comb begin
        shifted   = {rem_reg, quo_reg[SIZE_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[BB_W-1:0] : shifted[BB_W-1:0];
            quo_next = {quo_reg[SIZE_W-2:0], ge};
            if (cnt_reg == DIV_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.quo    = quo_reg;
    assign rsp.rem_nz = |rem_reg;

endmodule

// ===== rtl/core/fcba_table.sv =====
`timescale 1ns / 1ps

module fcba_table #(
    parameter int FAT_ENTRIES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fcba_pkg::tbl_req_t req,
    output fcba_pkg::tbl_rsp_t rsp
);
    import fcba_pkg::*;

    localparam int AW = $clog2(FAT_ENTRIES);

    logic [MARK_W+IDX_W-1:0] mem [FAT_ENTRIES];
    logic [FAT_ENTRIES-1:0]  valid_reg;
    logic [MARK_W+IDX_W-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic                    same_addr;

    assign same_addr = req.we && (req.waddr[AW-1:0] == req.raddr[AW-1:0]);

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr[AW-1:0]] <= {req.wmark, req.wlink};
        end
    end

    // read with write-first bypass so a walk that revisits an entry sees the new mark
    always_ff @(posedge aclk) begin
        if (same_addr) begin
            rd_data_reg <= {req.wmark, req.wlink};
        end else begin
            rd_data_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    // per-entry valid bits stand in for the clear; an invalid entry reads as free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.clear) begin
                valid_reg <= '0;
            end else if (req.we) begin
                valid_reg[req.waddr[AW-1:0]] <= 1'b1;
            end
            rd_valid_reg <= same_addr ? 1'b1 : valid_reg[req.raddr[AW-1:0]];
        end
    end

    assign rsp.mark = rd_valid_reg ? rd_data_reg[MARK_W+IDX_W-1:IDX_W] : MARK_FREE;
    assign rsp.link = rd_data_reg[IDX_W-1:0];

endmodule

// ===== bench/fat_chain_block_allocator_tb.sv =====
`timescale 1ns / 1ps

module fat_chain_block_allocator_tb;

    import fcba_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam logic [APB_AW-1:0] BB_ADDR = APB_AW'(4 * int'(REG_BLOCK_BYTES));

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    first_index;
        logic [CNT_W-1:0]    block_count;
        logic [IDX_W-1:0]    next_index;
        logic                is_end;
        logic                is_free;
    } op_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // size_bytes[17:0], start_index[23:18]
    logic [S_TDATA_W-1:0]  s_tdata;
    // mode[1:0]
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // first_index[5:0], block_count[12:6], next_index[18:13], is_end[19], is_free[20]
    logic [M_TDATA_W-1:0]  m_tdata;
    // status[1:0]
    logic [STATUS_W-1:0]   m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // shadow of the allocation table and the block size register
    logic [MARK_W-1:0]     fat_mark [TABLE_DEPTH];
    logic [IDX_W-1:0]      fat_link [TABLE_DEPTH];
    logic [BB_W-1:0]       blk_bytes = BB_RESET;

    op_result_t            due_results [$];
    int                    chain_heads [$];
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    fail_count = 0;
    int                    results_seen = 0;
    int                    ops_sent = 0;
    int                    allocs_granted = 0;
    int                    allocs_refused = 0;
    int                    chains_freed = 0;
    int                    sizes_tried = 1;

    fat_chain_block_allocator #(
        .FAT_ENTRIES(TABLE_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        if (fail_count < 100) begin
            $display("[%0t] mismatch at result %0d, %s: got %0d, expected %0d",
                     $realtime, results_seen, what, got_v, want_v);
        end
        fail_count++;
    endtask

    // effect of one operation on the table shadow, and the result it gives
    function automatic op_result_t compute_fat_result(input logic [MODE_W-1:0] op,
                                                      input logic [SIZE_W-1:0] size,
                                                      input logic [IDX_W-1:0] idx);
        op_result_t r;
        int unsigned bsz, need, avail, got, prev, cur, steps;
        logic [MARK_W-1:0] m;
        r = '0;
        case (op)
            MODE_CLEAR: begin
                foreach (fat_mark[i]) fat_mark[i] = MARK_FREE;
            end
            MODE_ALLOC: begin
                bsz = (blk_bytes == 0) ? 1 : blk_bytes;
                if (size == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    need = (size + bsz - 1) / bsz;
                    avail = 0;
                    foreach (fat_mark[i]) if (fat_mark[i] == MARK_FREE) avail++;
                    if (need > avail) begin
                        r.status = STAT_NO_SPACE;
                    end else begin
                        got = 0;
                        prev = 0;
                        for (int i = 0; i < TABLE_DEPTH && got < need; i++) begin
                            if (fat_mark[i] == MARK_FREE) begin
                                if (got == 0) begin
                                    r.first_index = IDX_W'(i);
                                end else begin
                                    fat_mark[prev] = MARK_LINK;
                                    fat_link[prev] = IDX_W'(i);
                                end
                                fat_mark[i] = MARK_END;
                                prev = i;
                                got++;
                            end
                        end
                        r.status = STAT_OK;
                        r.block_count = CNT_W'(got);
                    end
                end
            end
            MODE_FREE: begin
                if (fat_mark[idx] == MARK_FREE) begin
                    r.status = STAT_BAD;
                end else begin
                    cur = idx;
                    got = 0;
                    for (steps = 0; steps < TABLE_DEPTH; steps++) begin
                        m = fat_mark[cur];
                        if (m == MARK_FREE) break;
                        fat_mark[cur] = MARK_FREE;
                        got++;
                        if (m != MARK_LINK) break;
                        cur = fat_link[cur];
                    end
                    r.status = STAT_OK;
                    r.block_count = CNT_W'(got);
                end
            end
            default: begin
                m = fat_mark[idx];
                r.status = STAT_OK;
                r.next_index = (m == MARK_LINK) ? fat_link[idx] : '0;
                r.is_end = (m == MARK_END || m == MARK_RSVD);
                r.is_free = (m == MARK_FREE);
            end
        endcase
        return r;
    endfunction

    // entered and left just after a falling edge
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [SIZE_W-1:0] size,
                           input logic [IDX_W-1:0] idx);
        op_result_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {idx, size};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        want = compute_fat_result(op, size, idx);
        due_results.push_back(want);
        ops_sent++;
        if (op == MODE_ALLOC && want.status == STAT_OK) begin
            chain_heads.push_back(want.first_index);
            allocs_granted++;
        end
        if (op == MODE_ALLOC && want.status == STAT_NO_SPACE) allocs_refused++;
        if (op == MODE_FREE && want.status == STAT_OK) chains_freed++;
        if (op == MODE_CLEAR) chain_heads.delete();
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic check_block_bytes_reg(input logic [BB_W-1:0] want);
        logic [APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= BB_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        if (rd !== APB_DW'(want)) report_mismatch("block_bytes readback", rd, want);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_block_bytes(input logic [BB_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BB_ADDR;
        pwdata  <= APB_DW'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        blk_bytes = value;
        sizes_tried++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        check_block_bytes_reg(value);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        op_result_t got;
        op_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status      = m_tuser;
            got.first_index = m_tdata[5:0];
            got.block_count = m_tdata[12:6];
            got.next_index  = m_tdata[18:13];
            got.is_end      = m_tdata[19];
            got.is_free     = m_tdata[20];
            if (due_results.size() == 0) begin
                report_mismatch("transfer with nothing pending", got.status, 0);
            end else begin
                want = due_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.first_index !== want.first_index)
                    report_mismatch("first_index", got.first_index, want.first_index);
                if (got.block_count !== want.block_count)
                    report_mismatch("block_count", got.block_count, want.block_count);
                if (got.next_index !== want.next_index)
                    report_mismatch("next_index", got.next_index, want.next_index);
                if (got.is_end !== want.is_end)
                    report_mismatch("is_end", got.is_end, want.is_end);
                if (got.is_free !== want.is_free)
                    report_mismatch("is_free", got.is_free, want.is_free);
                if (m_tdata[23:21] !== 3'b000)
                    report_mismatch("tdata fill", m_tdata[23:21], 0);
            end
            results_seen++;
        end
    end

    task automatic test_reset_state();
        check_block_bytes_reg(BB_RESET);
        send_op(MODE_READ, 18'h3FFFF, 6'd5);
        send_op(MODE_ALLOC, 18'd0, 6'd63);
    endtask

    task automatic test_allocate_basics();
        send_op(MODE_ALLOC, 18'd1, 6'd0);
        send_op(MODE_ALLOC, 18'd1536, 6'd0);
        send_op(MODE_ALLOC, 18'd513, 6'd0);
        // far more blocks than the table holds
        send_op(MODE_ALLOC, 18'h3FFFF, 6'd0);
        send_op(MODE_READ, 18'd0, 6'd1);
        send_op(MODE_READ, 18'd0, 6'd3);
    endtask

    task automatic test_free_and_broken_chains();
        send_op(MODE_FREE, 18'd0, 6'd10);
        send_op(MODE_FREE, 18'd0, 6'd2);
        // entry 1 now links to a free entry
        send_op(MODE_FREE, 18'd0, 6'd1);
        send_op(MODE_READ, 18'd0, 6'd2);
        send_op(MODE_FREE, 18'd0, 6'd0);
        send_op(MODE_CLEAR, 18'h3FFFF, 6'd63);
        send_op(MODE_READ, 18'd0, 6'd4);
    endtask

    task automatic test_zero_block_size_exact_fit();
        // zero block size acts as one byte per block
        write_block_bytes('0);
        send_op(MODE_ALLOC, 18'd64, 6'd0);
        send_op(MODE_ALLOC, 18'd1, 6'd0);
        send_op(MODE_READ, 18'd0, 6'd63);
        send_op(MODE_READ, 18'd0, 6'd62);
        // walk of the whole table
        send_op(MODE_FREE, 18'd0, 6'd0);
        send_op(MODE_READ, 18'd0, 6'd0);
        write_block_bytes(13'd4096);
        send_op(MODE_ALLOC, 18'h3FFFF, 6'd0);
        send_op(MODE_CLEAR, 18'd0, 6'd0);
        write_block_bytes(13'd1);
        send_op(MODE_ALLOC, 18'd65, 6'd0);
        send_op(MODE_ALLOC, 18'd64, 6'd0);
    endtask

    task automatic run_traffic(input int n_items);
        int unsigned bsz, nblk, lo, hi, pick, roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            bsz = (blk_bytes == 0) ? 1 : blk_bytes;
            if (roll < 40) begin
                nblk = ($urandom_range(19) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
                lo = (nblk - 1) * bsz + 1;
                hi = nblk * bsz;
                if (hi > SIZE_MAX) hi = SIZE_MAX;
                if (lo > hi) lo = hi;
                send_op(MODE_ALLOC, SIZE_W'($urandom_range(hi, lo)), IDX_W'($urandom_range(63)));
            end else if (roll < 70 && chain_heads.size() != 0) begin
                pick = $urandom_range(chain_heads.size() - 1);
                send_op(MODE_FREE, SIZE_W'($urandom_range(SIZE_MAX)), IDX_W'(chain_heads[pick]));
                chain_heads.delete(pick);
            end else if (roll < 85) begin
                send_op(MODE_READ, SIZE_W'($urandom_range(SIZE_MAX)), IDX_W'($urandom_range(63)));
            end else if (roll < 90) begin
                send_op(MODE_FREE, SIZE_W'($urandom_range(SIZE_MAX)), IDX_W'($urandom_range(63)));
            end else if (roll < 94) begin
                send_op(MODE_ALLOC, SIZE_W'($urandom_range(SIZE_MAX)), IDX_W'($urandom_range(63)));
            end else if (roll < 97) begin
                send_op(MODE_ALLOC, '0, IDX_W'($urandom_range(63)));
            end else begin
                send_op(MODE_CLEAR, SIZE_W'($urandom_range(SIZE_MAX)), IDX_W'($urandom_range(63)));
            end
        end
    endtask

    task automatic test_random_traffic();
        set_idling(0, 0);
        write_block_bytes(BB_RESET);
        run_traffic(200);
        write_block_bytes(13'd1);
        set_idling(52, 0);
        run_traffic(200);
        write_block_bytes(13'd4096);
        set_idling(0, 52);
        run_traffic(200);
        write_block_bytes('0);
        set_idling(33, 33);
        run_traffic(200);
        write_block_bytes(13'h1FFF);
        set_idling(0, 0);
        run_traffic(200);
        write_block_bytes(BB_W'($urandom_range(4096, 1)));
        set_idling(52, 0);
        run_traffic(200);
        write_block_bytes(BB_W'($urandom_range(64, 2)));
        set_idling(0, 52);
        run_traffic(200);
        write_block_bytes(13'd100);
        set_idling(33, 33);
        run_traffic(200);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_CLEAR;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        foreach (fat_mark[i]) begin
            fat_mark[i] = MARK_FREE;
            fat_link[i] = '0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_allocate_basics();
        test_free_and_broken_chains();
        test_zero_block_size_exact_fit();
        test_random_traffic();

        drain_results();
        repeat (10) @(negedge aclk);
        $display("ran %0d operations, %0d results checked, under %0d block size settings",
                 ops_sent, results_seen, sizes_tried);
        $display("allocations granted %0d, refused for space %0d, chains freed %0d",
                 allocs_granted, allocs_refused, chains_freed);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
